@@ hdl/i2cms_pkg.sv @@
// shared types and codes for the i2c master status sequencer
// no dependencies; used by i2cms_step and i2c_master_status_sequencer
package i2cms_pkg;

  localparam int CMD_W = 2;
  localparam int SLOT_W = 5;
  localparam int SLOT_COUNT = 2 ** SLOT_W;
  localparam int LEN_W = 6;
  localparam int PHASE_W = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EVENT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_TX_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RX_LENGTH = 1'd1;

  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_RESTART     = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
  localparam logic [7:0] ST_SLA_W_NACK  = 8'h20;
  localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST    = 8'h38;
  localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
  localparam logic [7:0] ST_SLA_R_NACK  = 8'h48;
  localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

  localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
  localparam logic [PHASE_W-1:0] PH_STARTED   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_RESTARTED = 3'd2;
  localparam logic [PHASE_W-1:0] PH_REP_START = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DATA_ACK  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DATA_NACK = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic              port;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        data_in;
    logic [7:0]        status_code;
  } item_t;

  typedef struct packed {
    logic               write_data;
    logic [7:0]         data_out;
    logic               set_start;
    logic               set_stop;
    logic               set_ack;
    logic               clear_ack;
    logic               clear_start;
    logic               clear_si;
    logic [PHASE_W-1:0] phase;
    logic               overflow;
  } result_t;

  typedef struct packed {
    logic               write_data;
    logic               set_start;
    logic               set_stop;
    logic               set_ack;
    logic               clear_ack;
    logic               clear_start;
    logic               clear_si;
    logic               overflow;
    logic [PHASE_W-1:0] phase;
    logic               tx_read;
    logic               rx_read;
    logic               rx_write;
  } ctl_t;

endpackage

@@ hdl/i2cms_step.sv @@
// per-item decision logic: phase, positions and bus controls for one beat
// depends on i2cms_pkg
module i2cms_step #(
  parameter int BUFFER_BYTES = 32,
  localparam int POS_W = $clog2(BUFFER_BYTES + 1),
  localparam int IDX_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1,
  localparam int CMP_W = (POS_W > i2cms_pkg::LEN_W) ? POS_W : i2cms_pkg::LEN_W
) (
  input  logic [i2cms_pkg::CMD_W-1:0]   command,
  input  logic [7:0]                    status_code,
  input  logic [i2cms_pkg::PHASE_W-1:0] phase,
  input  logic [POS_W-1:0]              tx_pos,
  input  logic [POS_W-1:0]              rx_pos,
  input  logic [i2cms_pkg::LEN_W-1:0]   tx_length,
  input  logic [i2cms_pkg::LEN_W-1:0]   rx_length,
  output i2cms_pkg::ctl_t               ctl,
  output logic [POS_W-1:0]              tx_pos_next,
  output logic [POS_W-1:0]              rx_pos_next,
  output logic [IDX_W-1:0]              tx_idx
);

  localparam logic [POS_W-1:0] FULL = POS_W'(BUFFER_BYTES);

  logic [POS_W-1:0] tx_base;
  logic             tx_full;
  logic             rx_full;
  logic [POS_W-1:0] rx_after;
  logic             take;

  assign tx_base = (command == i2cms_pkg::CMD_EVENT && status_code == i2cms_pkg::ST_START)
                   ? '0 : tx_pos;
  assign tx_full = (tx_base >= FULL);
  assign tx_idx = tx_full ? IDX_W'(BUFFER_BYTES - 1) : tx_base[IDX_W-1:0];
  assign rx_full = (rx_pos >= FULL);
  assign rx_after = rx_full ? FULL : rx_pos + POS_W'(1);

  always_comb begin
    ctl = '0;
    ctl.phase = phase;
    tx_pos_next = tx_pos;
    rx_pos_next = rx_pos;
    take = 1'b0;
    case (command)
      i2cms_pkg::CMD_LOAD: begin
      end
      i2cms_pkg::CMD_READ: begin
        ctl.rx_read = 1'b1;
      end
      i2cms_pkg::CMD_INIT: begin
        ctl.phase = i2cms_pkg::PH_IDLE;
        ctl.clear_ack = 1'b1;
        ctl.clear_si = 1'b1;
        ctl.clear_start = 1'b1;
      end
      default: begin
        ctl.clear_si = 1'b1;
        case (status_code)
          i2cms_pkg::ST_START: begin
            take = 1'b1;
            ctl.clear_start = 1'b1;
            ctl.phase = i2cms_pkg::PH_STARTED;
          end
          i2cms_pkg::ST_RESTART: begin
            rx_pos_next = '0;
            take = 1'b1;
            ctl.clear_start = 1'b1;
            ctl.phase = i2cms_pkg::PH_RESTARTED;
          end
          i2cms_pkg::ST_SLA_W_ACK: begin
            if (phase == i2cms_pkg::PH_STARTED) begin
              take = 1'b1;
              ctl.phase = i2cms_pkg::PH_DATA_ACK;
            end
          end
          i2cms_pkg::ST_DATA_W_ACK, i2cms_pkg::ST_DATA_W_NACK: begin
            if (CMP_W'(tx_pos) < CMP_W'(tx_length)) begin
              take = 1'b1;
              ctl.phase = i2cms_pkg::PH_DATA_ACK;
            end else if (rx_length != '0) begin
              ctl.set_start = 1'b1;
              ctl.phase = i2cms_pkg::PH_REP_START;
            end else begin
              ctl.set_stop = 1'b1;
              ctl.phase = i2cms_pkg::PH_DATA_NACK;
            end
          end
          i2cms_pkg::ST_SLA_R_ACK: begin
            if (rx_length == i2cms_pkg::LEN_W'(1)) begin
              ctl.clear_ack = 1'b1;
            end else begin
              ctl.set_ack = 1'b1;
            end
          end
          i2cms_pkg::ST_DATA_R_ACK: begin
            rx_pos_next = rx_after;
            ctl.overflow = rx_full;
            ctl.rx_write = !rx_full;
            if (CMP_W'(rx_after) < CMP_W'(rx_length)) begin
              ctl.phase = i2cms_pkg::PH_DATA_ACK;
              ctl.set_ack = 1'b1;
            end else begin
              ctl.phase = i2cms_pkg::PH_DATA_NACK;
              ctl.clear_ack = 1'b1;
            end
          end
          i2cms_pkg::ST_DATA_R_NACK: begin
            rx_pos_next = rx_after;
            ctl.overflow = rx_full;
            ctl.rx_write = !rx_full;
            ctl.phase = i2cms_pkg::PH_DATA_NACK;
            ctl.set_stop = 1'b1;
          end
          i2cms_pkg::ST_SLA_W_NACK, i2cms_pkg::ST_SLA_R_NACK: begin
            ctl.phase = i2cms_pkg::PH_DATA_NACK;
          end
          i2cms_pkg::ST_ARB_LOST: begin
          end
          default: begin
          end
        endcase
      end
    endcase
    if (take) begin
      ctl.write_data = 1'b1;
      ctl.tx_read = 1'b1;
      if (tx_full) begin
        tx_pos_next = FULL;
        ctl.overflow = 1'b1;
      end else begin
        tx_pos_next = tx_base + POS_W'(1);
      end
    end
  end

endmodule

@@ hdl/i2c_master_status_sequencer.sv @@
// top level of the i2c master status sequencer: pipeline, stores, port state
// depends on i2cms_pkg and i2cms_step
//
// item channel (item_valid/item_stall/item) carries host and bus engine beats:
// load a tx byte, a status event, read an rx byte, or init a port. every item
// gives exactly one beat on the result channel (result_valid/result_stall/result).
// cfg channel (cfg_valid/cfg_ready, always ready) writes tx_length at index 0
// and rx_length at index 1; write it only while no item is in flight.
// throughput: one item per cycle unless the receiver stalls; the tx and rx stores
// are each one write and one registered read per cycle, so an event and its store
// access complete in the same pass.
// reset clears the pipeline, positions, phases and lengths; store contents
// stay undefined until loaded, so no clearing pass is needed.
// when the receiver stalls, the result holds and the item in the input
// register waits; item_stall rises only while both stages are full.
module i2c_master_status_sequencer #(
  parameter int BUFFER_BYTES = 32,
  parameter int PORT_COUNT = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  i2cms_pkg::item_t                item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output i2cms_pkg::result_t              result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [i2cms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [i2cms_pkg::LEN_W-1:0]     cfg_data
);

  localparam int POS_W = $clog2(BUFFER_BYTES + 1);
  localparam int IDX_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int PW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int DEPTH = PORT_COUNT * BUFFER_BYTES;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                s1_valid;
  i2cms_pkg::item_t    s1;
  logic                adv;
  logic                fire;
  logic [PW-1:0]       p;
  logic [IDX_W-1:0]    slot_idx;
  logic [IDX_W-1:0]    slot_mod [i2cms_pkg::SLOT_COUNT];
  logic [AW-1:0]       base;

  logic [i2cms_pkg::LEN_W-1:0]   tx_length;
  logic [i2cms_pkg::LEN_W-1:0]   rx_length;
  logic [POS_W-1:0]              tx_pos [PORT_COUNT];
  logic [POS_W-1:0]              rx_pos [PORT_COUNT];
  logic [i2cms_pkg::PHASE_W-1:0] phase [PORT_COUNT];

  i2cms_pkg::ctl_t     ctl;
  logic [POS_W-1:0]    tx_pos_next;
  logic [POS_W-1:0]    rx_pos_next;
  logic [IDX_W-1:0]    tx_idx;

  logic [7:0]          tx_mem [DEPTH];
  logic [7:0]          rx_mem [DEPTH];
  logic [7:0]          tx_rdata;
  logic [7:0]          rx_rdata;
  i2cms_pkg::result_t  s2;
  logic                s2_tx;
  logic                s2_rx;

  for (genvar g = 0; g < i2cms_pkg::SLOT_COUNT; g++) begin : g_slot
    assign slot_mod[g] = IDX_W'(g % BUFFER_BYTES);
  end

  assign adv = !result_valid || !result_stall;
  assign item_stall = s1_valid && !adv;
  assign fire = s1_valid && adv;
  assign cfg_ready = 1'b1;

  assign p = (PORT_COUNT > 1) ? PW'(s1.port) : '0;
  assign slot_idx = slot_mod[s1.slot];
  assign base = AW'(int'(p) * BUFFER_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
    if (item_valid && !item_stall) begin
      s1 <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_length <= '0;
      rx_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        i2cms_pkg::REG_TX_LENGTH: tx_length <= cfg_data;
        i2cms_pkg::REG_RX_LENGTH: rx_length <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  i2cms_step #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_step (
    .command(s1.command),
    .status_code(s1.status_code),
    .phase(phase[p]),
    .tx_pos(tx_pos[p]),
    .rx_pos(rx_pos[p]),
    .tx_length(tx_length),
    .rx_length(rx_length),
    .ctl(ctl),
    .tx_pos_next(tx_pos_next),
    .rx_pos_next(rx_pos_next),
    .tx_idx(tx_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PORT_COUNT; i++) begin
        tx_pos[i] <= '0;
        rx_pos[i] <= '0;
        phase[i] <= i2cms_pkg::PH_IDLE;
      end
    end else if (fire) begin
      tx_pos[p] <= tx_pos_next;
      rx_pos[p] <= rx_pos_next;
      phase[p] <= ctl.phase;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1.command == i2cms_pkg::CMD_LOAD) begin
      tx_mem[base + AW'(slot_idx)] <= s1.data_in;
    end
    if (fire) begin
      tx_rdata <= tx_mem[base + AW'(tx_idx)];
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ctl.rx_write) begin
      rx_mem[base + AW'(rx_pos[p][IDX_W-1:0])] <= s1.data_in;
    end
    if (fire) begin
      rx_rdata <= rx_mem[base + AW'(slot_idx)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= s1_valid;
    end
    if (fire) begin
      s2.write_data <= ctl.write_data;
      s2.data_out <= '0;
      s2.set_start <= ctl.set_start;
      s2.set_stop <= ctl.set_stop;
      s2.set_ack <= ctl.set_ack;
      s2.clear_ack <= ctl.clear_ack;
      s2.clear_start <= ctl.clear_start;
      s2.clear_si <= ctl.clear_si;
      s2.phase <= ctl.phase;
      s2.overflow <= ctl.overflow;
      s2_tx <= ctl.tx_read;
      s2_rx <= ctl.rx_read;
    end
  end

  always_comb begin
    result = s2;
    if (s2_tx) begin
      result.data_out = tx_rdata;
    end else if (s2_rx) begin
      result.data_out = rx_rdata;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && result_stall))
    else $error("item stalled while result stage could advance");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> result_valid)
    else $error("advanced beat produced no result");

  a_write_uses_tx: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.write_data) |-> (s2_tx && !s2_rx))
    else $error("write_data without a tx store read");

  a_reset_empties: assert property (@(posedge clk)
    $past(rst) |-> (!result_valid && !s1_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule
